FILE: design/assert_macros.svh
// Assertion macros for the allocator design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/ffcpa_pkg.sv
// Shared types and constants for the chunk pool allocator.
package ffcpa_pkg;
    localparam int NUM_PAGES = 8;
    localparam int CHUNK_BYTES = 32;
    localparam int PAGE_BYTES = 4096;
    localparam int UNITS = PAGE_BYTES / CHUNK_BYTES - 1;
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int UNIT_W = $clog2(UNITS + 1);

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic page_load;  // read page row into working regs
        logic scan_step;  // one unit of run search
        logic commit;     // write back row and count
        logic next_page;
    } ffcpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic early_done;  // zero, oversize or bad address known at load
        logic is_free;
        logic page_ok;     // free count large enough
        logic found;
        logic scan_end;
        logic last_page;
        logic free_ok;
    } ffcpa_stat_t;
endpackage

FILE: design/first_fit_chunk_pool_allocator.sv
// Top level of the first-fit chunk pool allocator.
// Pool of 8 pages of 4096 bytes; each page has a 32-byte header and 127 units of
// 32 bytes. One request item gives one result item. Zero, oversize and free
// requests are settled at the check step. An allocate walks pages in order,
// skipping each page whose free count is too small and searching the rest,
// where the run search steps one unit a cycle through the page's occupancy
// row. One request is in work at a time; the result register lets the next
// request enter while a result waits.
module first_fit_chunk_pool_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // size_bytes[12:0], address[27:13], zero pad
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[2:0], chunk_address[17:3], units_taken[24:18], zero pad
);
    ffcpa_pkg::ffcpa_cmd_t  cmd;
    ffcpa_pkg::ffcpa_stat_t stat;
    logic idle, done, in_fire;
    logic [2:0] st;
    logic [14:0] ad;
    logic [6:0] un;
    logic        ovalid_reg;
    logic [24:0] odata_reg;

    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    ffcpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(ovalid_reg && !m_axis_tready),
        .stat(stat), .cmd(cmd), .idle(idle), .done(done)
    );

    ffcpa_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_command(s_axis_tuser), .in_size(s_axis_tdata[12:0]),
        .in_address(s_axis_tdata[27:13]), .stat(stat),
        .res_status(st), .res_address(ad), .res_units(un)
    );

    // output register, freed when the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (done)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            odata_reg <= {un, ad, st};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {7'd0, odata_reg};
endmodule

FILE: design/ffcpa_ctrl.sv
// Sequencer for the chunk pool allocator.
`include "assert_macros.svh"
module ffcpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_busy,
    input  ffcpa_pkg::ffcpa_stat_t stat,
    output ffcpa_pkg::ffcpa_cmd_t  cmd,
    output logic                  idle,
    output logic                  done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PAGE = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        done = 1'b0;
        idle = (state_reg == S_IDLE);
        cmd.load = idle && in_fire;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.early_done)
                    state_next = S_DONE;
                else if (stat.is_free)
                begin
                    cmd.commit = stat.free_ok;
                    state_next = S_DONE;
                end
                else
                    state_next = S_PAGE;
            end
            S_PAGE:
            begin
                if (stat.page_ok)
                begin
                    cmd.page_load = 1'b1;
                    state_next = S_SCAN;
                end
                else if (stat.last_page)
                    state_next = S_DONE;
                else
                    cmd.next_page = 1'b1;
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.scan_end)
                begin
                    if (stat.last_page)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.next_page = 1'b1;
                        state_next = S_PAGE;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_NEVER(a_commit_once, clk, rst_n, cmd.commit && cmd.next_page, "commit and advance")
    `ASSERT_CLK(a_done_idle, clk, rst_n, done |=> idle, "done must return to idle")
    `ASSERT_NEVER(a_load_busy, clk, rst_n, in_fire && !idle && cmd.load, "load while busy")
endmodule

FILE: design/ffcpa_dp.sv
// Datapath: occupancy rows, free counts and the unit-serial run search.
`include "assert_macros.svh"
module ffcpa_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffcpa_pkg::ffcpa_cmd_t  cmd,
    input  logic                  in_command,
    input  logic [12:0]           in_size,
    input  logic [14:0]           in_address,
    output ffcpa_pkg::ffcpa_stat_t stat,
    output logic [2:0]            res_status,
    output logic [14:0]           res_address,
    output logic [6:0]            res_units
);
    localparam int U = ffcpa_pkg::UNITS;
    localparam int UW = ffcpa_pkg::UNIT_W;
    localparam int PW = ffcpa_pkg::PAGE_W;
    localparam int CSH = $clog2(ffcpa_pkg::CHUNK_BYTES);
    localparam int PSH = $clog2(ffcpa_pkg::PAGE_BYTES);

    logic [U-1:0]  occ_reg [ffcpa_pkg::NUM_PAGES];
    logic [UW-1:0] cnt_reg [ffcpa_pkg::NUM_PAGES];

    logic          cmd_reg;
    logic [UW:0]   n_reg;
    logic [PW-1:0] page_reg;
    logic [UW-1:0] off_reg;
    logic          bad_reg;
    logic [2:0]    early_reg;
    logic [U-1:0]  row_reg;
    logic [UW-1:0] pos_reg;
    logic [UW:0]   run_reg;
    logic [2:0]    status_reg;
    logic [14:0]   addr_reg;
    logic [6:0]    units_reg;

    logic [13:0]   size_up;
    logic [13-CSH:0] n_full;
    logic [U-1:0]  mask;
    logic [U-1:0]  run_mask;
    logic [UW:0]   run_inc;
    logic [UW-1:0] start;
    logic [14:0]   alloc_addr;

    assign size_up = {1'b0, in_size} + 14'(ffcpa_pkg::CHUNK_BYTES - 1);
    assign n_full = size_up[13:CSH];

    // run of n ones starting at off
    assign mask = (U'((U+1)'(1) << n_reg) - U'(1)) << off_reg;
    assign run_inc = row_reg[pos_reg] ? '0 : run_reg + 1'b1;
    assign start = UW'(pos_reg + 1'b1 - n_reg);
    assign run_mask = (U'((U+1)'(1) << n_reg) - U'(1)) << start;
    assign alloc_addr = 15'((32'(page_reg) << PSH) + (32'(start + 1'b1) << CSH));

    always_comb
    begin
        stat.early_done = (early_reg != ffcpa_pkg::ST_OK) || (cmd_reg && bad_reg);
        stat.is_free = cmd_reg;
        stat.page_ok = {1'b0, cnt_reg[page_reg]} >= n_reg;
        stat.found = (run_inc >= n_reg);
        stat.scan_end = (pos_reg == UW'(U - 1));
        stat.last_page = (page_reg == PW'(ffcpa_pkg::NUM_PAGES - 1));
        stat.free_ok = ((occ_reg[page_reg] & mask) == mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < ffcpa_pkg::NUM_PAGES; p++)
            begin
                occ_reg[p] <= '0;
                cnt_reg[p] <= UW'(U);
            end
        end
        else if (cmd.commit)
        begin
            if (cmd_reg)
            begin
                occ_reg[page_reg] <= occ_reg[page_reg] & ~mask;
                cnt_reg[page_reg] <= UW'(cnt_reg[page_reg] + n_reg);
            end
            else
            begin
                occ_reg[page_reg] <= row_reg | run_mask;
                cnt_reg[page_reg] <= UW'(cnt_reg[page_reg] - n_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_command;
            n_reg <= (UW+1)'(n_full);
            if (in_command == ffcpa_pkg::CMD_FREE)
                page_reg <= PW'(in_address >> PSH);
            else
                page_reg <= '0;
            off_reg <= UW'((in_address[PSH-1:0] >> CSH) - 1);
            bad_reg <= ((32'(in_address) >> PSH) >= ffcpa_pkg::NUM_PAGES)
                || (in_address[CSH-1:0] != '0)
                || (in_address[PSH-1:CSH] == '0)
                || (32'(in_address[PSH-1:CSH]) - 1 + 32'(n_full) > U);
            if (in_size == '0)
                early_reg <= ffcpa_pkg::ST_ZERO;
            else if (32'(n_full) > U)
                early_reg <= ffcpa_pkg::ST_TOO_LARGE;
            else
                early_reg <= ffcpa_pkg::ST_OK;
            addr_reg <= '0;
            units_reg <= '0;
            if (in_size == '0)
                status_reg <= ffcpa_pkg::ST_ZERO;
            else if (32'(n_full) > U)
                status_reg <= ffcpa_pkg::ST_TOO_LARGE;
            else if (in_command == ffcpa_pkg::CMD_FREE)
                status_reg <= ffcpa_pkg::ST_BAD_ADDR;
            else
                status_reg <= ffcpa_pkg::ST_NO_SPACE;
        end
        if (cmd.page_load)
        begin
            row_reg <= occ_reg[page_reg];
            pos_reg <= '0;
            run_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            run_reg <= run_inc;
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.next_page)
            page_reg <= page_reg + 1'b1;
        if (cmd.commit)
        begin
            status_reg <= ffcpa_pkg::ST_OK;
            units_reg <= 7'(n_reg);
            addr_reg <= cmd_reg ? 15'd0 : alloc_addr;
        end
    end

    assign res_status = status_reg;
    assign res_address = addr_reg;
    assign res_units = units_reg;

    `ASSERT_CLK(a_cnt_range, clk, rst_n, cmd.commit |-> (cnt_reg[page_reg] <= UW'(U)), "free count overflow")
    `ASSERT_CLK(a_alloc_fits, clk, rst_n, (cmd.commit && !cmd_reg) |-> ((row_reg & run_mask) == '0), "alloc over used units")
    `ASSERT_CLK(a_free_full, clk, rst_n, (cmd.commit && cmd_reg) |-> stat.free_ok, "free of free units")
endmodule

FILE: dv/ffcpa_checker.sv
// Checker for the chunk pool allocator: predicts each request's result and compares in order.
`timescale 1ns / 1ps

module ffcpa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // size_bytes[12:0], address[27:13], zero pad
    input  logic        s_axis_tuser,   // command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // status[2:0], chunk_address[17:3], units_taken[24:18]
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] chunk_address;
        logic [6:0]  units_taken;
    } alloc_result_t;

    alloc_result_t             expected_q[$];
    logic [ffcpa_pkg::UNITS-1:0] unit_busy[ffcpa_pkg::NUM_PAGES];
    int                        page_free[ffcpa_pkg::NUM_PAGES];

    function automatic alloc_result_t pool_step(logic cmd, logic [12:0] size,
                                                logic [14:0] addr);
        alloc_result_t r;
        int n, p, u, s, run, pg, off;
        r = '0;
        if (size == 0) begin
            r.status = ffcpa_pkg::ST_ZERO;
            return r;
        end
        n = (size + ffcpa_pkg::CHUNK_BYTES - 1) / ffcpa_pkg::CHUNK_BYTES;
        if (n > ffcpa_pkg::UNITS) begin
            r.status = ffcpa_pkg::ST_TOO_LARGE;
            return r;
        end
        if (cmd == ffcpa_pkg::CMD_ALLOC) begin
            for (p = 0; p < ffcpa_pkg::NUM_PAGES; p++) begin
                if (page_free[p] < n)
                    continue;
                run = 0;
                s = -1;
                for (u = 0; u < ffcpa_pkg::UNITS && s < 0; u++) begin
                    if (unit_busy[p][u])
                        run = 0;
                    else begin
                        run++;
                        if (run >= n)
                            s = u + 1 - n;
                    end
                end
                if (s < 0)
                    continue;
                for (u = 0; u < n; u++)
                    unit_busy[p][s + u] = 1'b1;
                page_free[p] -= n;
                r.status = ffcpa_pkg::ST_OK;
                r.chunk_address = 15'(p * ffcpa_pkg::PAGE_BYTES
                                      + ffcpa_pkg::CHUNK_BYTES * (s + 1));
                r.units_taken = 7'(n);
                return r;
            end
            r.status = ffcpa_pkg::ST_NO_SPACE;
            return r;
        end
        // free: page range, alignment, header, page end, double free
        pg = addr / ffcpa_pkg::PAGE_BYTES;
        off = addr % ffcpa_pkg::PAGE_BYTES;
        r.status = ffcpa_pkg::ST_BAD_ADDR;
        if (pg >= ffcpa_pkg::NUM_PAGES || off % ffcpa_pkg::CHUNK_BYTES != 0
            || off < ffcpa_pkg::CHUNK_BYTES)
            return r;
        off = off / ffcpa_pkg::CHUNK_BYTES - 1;
        if (off + n > ffcpa_pkg::UNITS)
            return r;
        for (u = 0; u < n; u++)
            if (!unit_busy[pg][off + u])
                return r;
        for (u = 0; u < n; u++)
            unit_busy[pg][off + u] = 1'b0;
        page_free[pg] += n;
        r.status = ffcpa_pkg::ST_OK;
        r.units_taken = 7'(n);
        return r;
    endfunction

    initial
    begin
        errors = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n) begin
            expected_q.delete();
            for (int p = 0; p < ffcpa_pkg::NUM_PAGES; p++) begin
                unit_busy[p] = '0;
                page_free[p] = ffcpa_pkg::UNITS;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(pool_step(s_axis_tuser, s_axis_tdata[12:0],
                                               s_axis_tdata[27:13]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result item %h", $realtime, m_axis_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.status
                        || m_axis_tdata[17:3] !== want.chunk_address
                        || m_axis_tdata[24:18] !== want.units_taken) begin
                        errors++;
                        $display("%0t: expected status %0d addr %h units %0d, got %0d %h %0d",
                                 $realtime, want.status, want.chunk_address,
                                 want.units_taken, m_axis_tdata[2:0],
                                 m_axis_tdata[17:3], m_axis_tdata[24:18]);
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

FILE: dv/first_fit_chunk_pool_allocator_test.sv
// Testbench top for the chunk pool allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module first_fit_chunk_pool_allocator_test;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int RANDOM_ITEMS = 1000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // size_bytes[12:0], address[27:13], zero pad
    logic        s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // status[2:0], chunk_address[17:3], units_taken[24:18]
    int          errors;
    int          outstanding;

    // request in flight, kept to learn which allocations succeeded
    typedef struct {
        logic        cmd;
        logic [12:0] size;
    } request_t;

    // chunk currently held by the stimulus, a candidate for a clean free
    typedef struct {
        logic [14:0] addr;
        int          units;
    } chunk_t;

    request_t in_flight[$];
    chunk_t   held[$];
    int       status_seen[5];
    int       cycles;
    bit       hold_go;

    first_fit_chunk_pool_allocator u_top (.*);

    ffcpa_checker u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("first_fit_chunk_pool_allocator verification failed");
            $finish;
        end
    end

    // track results: successful allocations become free candidates
    always @(posedge clk)
    begin
        request_t req;
        chunk_t   c;
        if (rst_n && m_axis_tvalid && m_axis_tready && in_flight.size() > 0) begin
            req = in_flight.pop_front();
            if (m_axis_tdata[2:0] <= ffcpa_pkg::ST_BAD_ADDR)
                status_seen[m_axis_tdata[2:0]]++;
            if (req.cmd == ffcpa_pkg::CMD_ALLOC && m_axis_tdata[2:0] == ffcpa_pkg::ST_OK) begin
                c.addr = m_axis_tdata[17:3];
                c.units = (req.size + ffcpa_pkg::CHUNK_BYTES - 1) / ffcpa_pkg::CHUNK_BYTES;
                held.push_back(c);
            end
        end
    end

    // receiver: stall pattern re-picked from three modes, plus one long hold-off
    always @(posedge clk)
    begin
        int hold_left;
        int mode;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else begin
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = 600;
            end
            if (cycles % 64 == 0)
                mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (mode == 0)
                m_axis_tready <= 1'b1;
            else if (mode == 1)
                m_axis_tready <= $urandom_range(0, 1);
            else
                m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // offer one item and wait for it to be taken; tvalid stays high afterward
    task automatic send_item(logic cmd, int size, int addr);
        request_t req;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0, 15'(addr), 13'(size)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        req.cmd = cmd;
        req.size = 13'(size);
        in_flight.push_back(req);
    endtask

    task automatic go_idle(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        go_idle(1);
        while (in_flight.size() > 0)
            @(posedge clk);
    endtask

    // free a held chunk, all of it or only its head part
    task automatic free_held(bit whole);
        int     idx, k;
        chunk_t c;
        idx = $urandom_range(0, held.size() - 1);
        c = held[idx];
        held.delete(idx);
        k = (whole || c.units == 1) ? c.units : $urandom_range(1, c.units - 1);
        if (k < c.units)
            held.push_back('{addr: c.addr + 15'(k * ffcpa_pkg::CHUNK_BYTES),
                             units: c.units - k});
        send_item(ffcpa_pkg::CMD_FREE,
                  k * ffcpa_pkg::CHUNK_BYTES - $urandom_range(0, ffcpa_pkg::CHUNK_BYTES - 1),
                  c.addr);
    endtask

    initial
    begin
        int burst, pick, sz;
        chunk_t c;
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        hold_go = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ffcpa_pkg::CMD_ALLOC;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: size edges, refusals, each kind of bad free
        send_item(ffcpa_pkg::CMD_ALLOC, 1, 32767);
        send_item(ffcpa_pkg::CMD_ALLOC, 32, 0);
        send_item(ffcpa_pkg::CMD_ALLOC, 33, 0);
        send_item(ffcpa_pkg::CMD_ALLOC, 4064, 0);       // whole page
        send_item(ffcpa_pkg::CMD_ALLOC, 4065, 0);       // one unit too many
        send_item(ffcpa_pkg::CMD_ALLOC, 8191, 0);
        send_item(ffcpa_pkg::CMD_ALLOC, 0, 0);
        send_item(ffcpa_pkg::CMD_FREE, 0, 32);
        send_item(ffcpa_pkg::CMD_FREE, 8191, 32);
        send_item(ffcpa_pkg::CMD_FREE, 32, 4096);       // page header
        send_item(ffcpa_pkg::CMD_FREE, 32, 33);         // not on a unit boundary
        send_item(ffcpa_pkg::CMD_FREE, 32, 32767);
        send_item(ffcpa_pkg::CMD_FREE, 64, 4064);       // runs past page end
        send_item(ffcpa_pkg::CMD_FREE, 32, 3200);       // never allocated
        drain();
        c = held[0];
        send_item(ffcpa_pkg::CMD_FREE, c.units * ffcpa_pkg::CHUNK_BYTES, c.addr);
        send_item(ffcpa_pkg::CMD_FREE, c.units * ffcpa_pkg::CHUNK_BYTES, c.addr); // double free
        held.delete(0);
        // fill the pool until allocations are refused
        repeat (8) send_item(ffcpa_pkg::CMD_ALLOC, 4064, 0);
        drain();
        while (held.size() > 0)
            free_held(1'b1);
        drain();

        // random: mostly allocate/free traffic on held chunks, some noise
        burst = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (burst == 0) begin
                go_idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            burst--;
            if (i == 300)
                hold_go = 1'b1;
            if (i == 600)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                pick = $urandom_range(0, 9);
                sz = pick < 7 ? $urandom_range(1, 512)
                   : pick < 9 ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
                send_item(ffcpa_pkg::CMD_ALLOC, sz, $urandom_range(0, 32767));
            end else if (pick < 88 && held.size() > 0)
                free_held($urandom_range(0, 4) != 0);
            else
                send_item($urandom_range(0, 1), $urandom_range(0, 8191),
                          $urandom_range(0, 1) ? $urandom_range(0, 32767)
                                               : 32 * $urandom_range(0, 1023));
        end
        drain();
        repeat (1200) @(posedge clk);

        $display("Results: ok %0d, no space %0d, too large %0d, zero %0d, bad address %0d",
                 status_seen[ffcpa_pkg::ST_OK], status_seen[ffcpa_pkg::ST_NO_SPACE],
                 status_seen[ffcpa_pkg::ST_TOO_LARGE], status_seen[ffcpa_pkg::ST_ZERO],
                 status_seen[ffcpa_pkg::ST_BAD_ADDR]);
        if (errors == 0 && outstanding == 0)
            $display("first_fit_chunk_pool_allocator verification clean");
        else
            $display("first_fit_chunk_pool_allocator verification failed");
        $finish;
    end

endmodule
